// ===== sv/spq_pkg.sv =====
// Shared types and codes for the stable priority queue.
// No dependencies; used by spq_cell and stable_priority_queue.
`default_nettype none

package spq_pkg;

    localparam int DATA_W = 32;
    localparam int PRIO_W = 16;
    localparam int FILL_W = 5;

    // Operation carried in the input tuser
    typedef enum logic {
        FUNC_INSERT = 1'b0,
        FUNC_REMOVE = 1'b1
    } func_t;

    // Result status carried in the output tuser
    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_OVERFLOW  = 2'd2
    } status_t;

    // One queue entry
    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic [PRIO_W-1:0] prio;
    } entry_t;

    // Command broadcast to every cell in the row
    typedef struct packed {
        logic   ins;     // insert new entry (queue not full)
        logic   rem;     // pop head, shift row toward head (queue not empty)
        entry_t entry;   // entry being inserted
    } cell_cmd_t;

endpackage

`default_nettype wire

// ===== sv/spq_cell.sv =====
// One cell of the sorted row: holds one entry and trades it with neighbors.
// Depends on spq_pkg.
`default_nettype none

module spq_cell #(
    parameter int IDX = 0,
    parameter int CW  = 5
) (
    input  wire                     clk,
    input  wire  [CW-1:0]           count,
    input  wire spq_pkg::cell_cmd_t cmd,
    input  wire spq_pkg::entry_t    left_entry,
    input  wire                     left_after,
    input  wire spq_pkg::entry_t    right_entry,
    output spq_pkg::entry_t         entry,
    output logic                    after
);

    spq_pkg::entry_t entry_reg;
    spq_pkg::entry_t entry_next;
    logic            occupied;

    // Cell holds a live entry when it sits below the fill count
    assign occupied = CW'(IDX) < count;
    // New entry lands behind this one (older entries win ties)
    assign after    = occupied && (entry_reg.prio <= cmd.entry.prio);

    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.ins && !after)
        begin
            entry_next = left_after ? cmd.entry : left_entry;
        end
        else if (cmd.rem)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

`default_nettype wire

// ===== sv/stable_priority_queue.sv =====
// A result is valid the cycle after its request is accepted.
// Throughput: one request per cycle while s_tready is high; cells update at once.
// A request is taken whenever the result register is empty or being drained.
// Reset clears the fill count and the result valid; cell contents stay
// undefined until written and are never read past the fill count.
// Top level: row of spq_cell instances plus count and result register.
// Depends on spq_pkg and spq_cell.
`default_nettype none

module stable_priority_queue #(
    parameter int DEPTH = 16
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [47:0] s_tdata,   // item_data[31:0], item_priority[47:32]
    input  wire  [0:0]  s_tuser,   // func[0]
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [55:0] m_tdata,   // removed_data[31:0], removed_priority[47:32],
                                   // fill_level[52:48], zero pad[55:53]
    output logic [1:0]  m_tuser    // status[1:0]
);

    localparam int CW = $clog2(DEPTH + 1);

    logic                 s_accept;
    spq_pkg::func_t       func;
    spq_pkg::cell_cmd_t   cmd;
    spq_pkg::entry_t      cell_entry [DEPTH];
    logic [DEPTH-1:0]     cell_after;
    logic                 is_full;
    logic                 is_empty;

    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        count_next;
    logic                 m_tvalid_reg;
    logic                 m_tvalid_next;
    logic [1:0]           status_reg;
    logic [1:0]           status_next;
    spq_pkg::entry_t      removed_reg;
    spq_pkg::entry_t      removed_next;
    logic [spq_pkg::FILL_W-1:0] fill_reg;
    logic [spq_pkg::FILL_W-1:0] fill_next;

    // Handshake
    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;
    assign func     = spq_pkg::func_t'(s_tuser[0]);
    assign is_full  = count_reg == CW'(DEPTH);
    assign is_empty = count_reg == '0;

    // Command to the cell row
    always_comb
    begin
        cmd.entry.data = s_tdata[31:0];
        cmd.entry.prio = s_tdata[47:32];
        cmd.ins = s_accept && (func == spq_pkg::FUNC_INSERT) && !is_full;
        cmd.rem = s_accept && (func == spq_pkg::FUNC_REMOVE) && !is_empty;
    end

    // Cell row: head at index 0
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        spq_pkg::entry_t left_e;
        spq_pkg::entry_t right_e;
        logic            left_a;

        if (g == 0)
        begin : g_head
            assign left_e = cmd.entry;
            assign left_a = 1'b1;
        end
        else
        begin : g_body
            assign left_e = cell_entry[g-1];
            assign left_a = cell_after[g-1];
        end

        if (g == DEPTH - 1)
        begin : g_tail
            assign right_e = cmd.entry;
        end
        else
        begin : g_inner
            assign right_e = cell_entry[g+1];
        end

        spq_cell #(
            .IDX (g),
            .CW  (CW)
        ) u_cell (
            .clk         (clk),
            .count       (count_reg),
            .cmd         (cmd),
            .left_entry  (left_e),
            .left_after  (left_a),
            .right_entry (right_e),
            .entry       (cell_entry[g]),
            .after       (cell_after[g])
        );
    end

    // Fill count and result
    always_comb
    begin
        count_next    = count_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        status_next   = status_reg;
        removed_next  = removed_reg;
        if (cmd.ins)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.rem)
        begin
            count_next = count_reg - CW'(1);
        end
        fill_next = s_accept ? spq_pkg::FILL_W'(count_next) : fill_reg;
        if (s_accept)
        begin
            m_tvalid_next = 1'b1;
            removed_next  = '0;
            status_next   = spq_pkg::ST_DONE;
            if (func == spq_pkg::FUNC_INSERT)
            begin
                if (is_full)
                begin
                    status_next = spq_pkg::ST_OVERFLOW;
                end
            end
            else if (is_empty)
            begin
                status_next = spq_pkg::ST_UNDERFLOW;
            end
            else
            begin
                removed_next = cell_entry[0];
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        status_reg  <= status_next;
        removed_reg <= removed_next;
        fill_reg    <= fill_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {3'b000, fill_reg, removed_reg.prio, removed_reg.data};

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("fill count above depth");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ins |=> count_reg == $past(count_reg) + CW'(1))
        else $error("insert did not grow the count");

    a_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept && (func == spq_pkg::FUNC_REMOVE) && is_empty
        |=> m_tvalid && (m_tuser == spq_pkg::ST_UNDERFLOW) && (m_tdata[47:0] == '0))
        else $error("remove on empty not flagged");

    a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg >= CW'(2) |-> cell_entry[0].prio <= cell_entry[1].prio)
        else $error("head pair out of order");

endmodule

`default_nettype wire
